// File: rtl/core/gcht_pkg.sv
// Package for the allocation hash table: constants, request and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package gcht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [CNT_W+1:0] LOAD_LIMIT = (CNT_W+2)'(3 * TABLE_DEPTH);

  // Entry record stored in the table memory: flags, size, address.
  localparam int ENT_W = 3 + 32 + 64;

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_LOOKUP = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_MARK   = 3'd3;
  localparam logic [2:0] REQ_SWEEP  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NFND  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADDR = 2'd3;

  localparam logic [0:0] CFG_GROW   = 1'd0;
  localparam logic [0:0] CFG_THRESH = 1'd1;

  localparam int FL_USE  = 0;
  localparam int FL_TOMB = 1;
  localparam int FL_MARK = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture request, start hash
    logic hash_step;   // one FNV round
    logic probe_init;  // index := hash mod depth
    logic probe_next;  // index := index + 1
    logic sweep_init;  // index := 0
    logic rd_en;       // read entry at index
    logic eval;        // evaluate read data (probe step)
    logic commit;      // apply insert/remove/mark result
    logic sweep_eval;  // apply sweep step to read data
    logic thr_mul;     // compute threshold partial products
    logic thr_set;     // store next threshold
    logic clr_step;    // clearing pass write
    logic result;      // load output register
  } gcht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req;
    logic       addr_zero;
    logic       hit;        // live match at index
    logic       empty;      // unused, not tombstone
    logic       last_idx;   // index is the final one
    logic       probe_last; // probe step count done
    logic       mark_oob;   // mark out of range
  } gcht_sts_t;

endpackage

// File: rtl/core/gcht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module gcht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write-first is not needed; read returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/gcht_ctrl.sv
// Controller state machine for the allocation hash table.
// Depends on gcht_pkg.
module gcht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_busy,
  input  gcht_pkg::gcht_sts_t sts,
  output logic                in_ready,
  output gcht_pkg::gcht_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PINIT, S_READ, S_EVAL, S_COMMIT,
    S_SRD, S_SEVAL, S_TMUL, S_TSET, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] hcnt_r, hcnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    hcnt_nxt = hcnt_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.probe_next = 1'b1;
        if (sts.last_idx) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_req = 1'b1;
          hcnt_nxt = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.req == gcht_pkg::REQ_SWEEP) begin
          cmd.sweep_init = 1'b1;
          state_nxt = S_SRD;
        end else if (sts.req > gcht_pkg::REQ_SWEEP || sts.addr_zero
                     || sts.mark_oob) begin
          state_nxt = S_DONE;
        end else begin
          cmd.hash_step = 1'b1;
          hcnt_nxt = hcnt_r + 2'd1;
          if (hcnt_r == 2'd3) state_nxt = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd.probe_init = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.hit || sts.empty || sts.probe_last) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_DONE;
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SEVAL;
      end
      S_SEVAL: begin
        cmd.sweep_eval = 1'b1;
        cmd.probe_next = 1'b1;
        state_nxt = sts.last_idx ? S_TMUL : S_SRD;
      end
      S_TMUL: begin
        cmd.thr_mul = 1'b1;
        state_nxt = S_TSET;
      end
      S_TSET: begin
        cmd.thr_set = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.result = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      hcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

endmodule

// File: rtl/core/gcht_dp.sv
// Datapath for the allocation hash table: hash, probe index, entry memory,
// counters, bounds, threshold and result register. Depends on gcht_pkg, gcht_ram.
module gcht_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gcht_pkg::gcht_cmd_t cmd,
  output gcht_pkg::gcht_sts_t sts,
  input  logic [2:0]          in_req,
  input  logic [63:0]         in_addr,
  input  logic [31:0]         in_size,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                out_take,
  output logic                out_valid,
  output logic [1:0]          o_status,
  output logic                o_found,
  output logic [31:0]         o_esize,
  output logic [63:0]         o_total,
  output logic [63:0]         o_freed,
  output logic                o_due
);

  localparam int IW = gcht_pkg::IDX_W;
  localparam int CW = gcht_pkg::CNT_W;

  logic [2:0]  req_r;
  logic [63:0] addr_r;
  logic [31:0] size_r;
  logic [31:0] hash_r;
  logic [1:0]  byte_r;
  logic [IW-1:0] idx_r;
  logic [IW:0]   steps_r;
  logic        have_tomb_r;
  logic [IW-1:0] tomb_r;
  logic        hit_r, reuse_r;
  logic [IW-1:0] pos_r;
  logic [31:0] old_size_r;
  logic [2:0]  old_flags_r;
  logic [CW-1:0] count_r;
  logic [63:0] alloc_r, low_r, high_r, thr_r, freed_r;
  logic [4:0]  grow_r;
  logic [36:0] thr_hi_r, thr_lo_r;
  logic [1:0]  st_r;

  // Memory port.
  logic          we;
  logic [IW-1:0] ram_addr;
  logic [gcht_pkg::ENT_W-1:0] wdata, rdata;
  logic [2:0]  rd_flags;
  logic [31:0] rd_size;
  logic [63:0] rd_addr;

  assign {rd_flags, rd_size, rd_addr} = rdata;

  gcht_ram #(.WIDTH(gcht_pkg::ENT_W), .DEPTH(gcht_pkg::TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  logic r_use, r_tomb, r_hit, r_empty;
  assign r_use = rd_flags[gcht_pkg::FL_USE];
  assign r_tomb = !r_use && rd_flags[gcht_pkg::FL_TOMB];
  assign r_hit = r_use && (rd_addr == addr_r);
  assign r_empty = !r_use && !r_tomb;

  assign sts.req = req_r;
  assign sts.addr_zero = (addr_r == 64'd0) && (req_r <= gcht_pkg::REQ_MARK);
  assign sts.mark_oob = (req_r == gcht_pkg::REQ_MARK) &&
                        ((count_r == '0) || addr_r < low_r || addr_r > high_r);
  assign sts.hit = r_hit;
  assign sts.empty = r_empty;
  assign sts.last_idx = &idx_r;
  assign sts.probe_last = (steps_r == (IW+1)'(gcht_pkg::TABLE_DEPTH - 1));

  // Entry write: clear pass, commit of insert/remove/mark, sweep.
  logic [63:0] top;
  logic        ins_new_ok;
  logic [CW+1:0] load_need;
  assign top = ({1'b0, addr_r} + 65'(size_r)) > 65'hFFFF_FFFF_FFFF_FFFF ? '1
               : addr_r + 64'(size_r);
  assign load_need = (CW+2)'({count_r, 2'b00}) + (CW+2)'(4);
  assign ins_new_ok = reuse_r && (load_need <= gcht_pkg::LOAD_LIMIT);

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    sat_sub = a > b ? a - b : 64'd0;
  endfunction
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? '1 : s[63:0];
  endfunction

  always_comb begin
    we = 1'b0;
    wdata = '0;
    ram_addr = idx_r;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.commit) begin
      ram_addr = pos_r;
      case (req_r)
        gcht_pkg::REQ_INSERT: begin
          // A live match keeps its flags, so a marked entry stays marked.
          we = hit_r || ins_new_ok;
          wdata = hit_r ? {old_flags_r, size_r, addr_r} : {3'b001, size_r, addr_r};
        end
        gcht_pkg::REQ_REMOVE: begin
          we = hit_r;
          wdata = {3'b010, 32'd0, 64'd0};
        end
        gcht_pkg::REQ_MARK: begin
          we = hit_r;
          wdata = {old_flags_r | 3'b100, old_size_r, addr_r};
        end
        default: we = 1'b0;
      endcase
    end else if (cmd.sweep_eval && r_use) begin
      we = 1'b1;
      wdata = rd_flags[gcht_pkg::FL_MARK] ? {3'b001, rd_size, rd_addr}
                                          : {3'b010, 32'd0, 64'd0};
    end
  end

  // Registers of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      alloc_r <= '0;
      low_r <= '1;
      high_r <= '0;
      thr_r <= 64'd1024;
      grow_r <= 5'd2;
      idx_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == gcht_pkg::CFG_GROW) grow_r <= cfg_data[4:0];
        else thr_r <= 64'(cfg_data);
      end
      if (cmd.load_req) begin
        req_r <= in_req;
        addr_r <= in_addr;
        size_r <= in_size;
        hash_r <= gcht_pkg::FNV_BASIS;
        byte_r <= '0;
        freed_r <= '0;
        st_r <= gcht_pkg::ST_OK;
        hit_r <= 1'b0;
        reuse_r <= 1'b0;
        old_size_r <= '0;
      end
      if (cmd.hash_step) begin
        hash_r <= (hash_r ^ 32'(addr_r[8*byte_r +: 8])) * gcht_pkg::FNV_PRIME;
        byte_r <= byte_r + 2'd1;
      end
      if (cmd.probe_init) begin
        idx_r <= hash_r[IW-1:0];
        steps_r <= '0;
        have_tomb_r <= 1'b0;
      end
      if (cmd.probe_next) begin
        idx_r <= idx_r + IW'(1);
        steps_r <= steps_r + (IW+1)'(1);
      end
      if (cmd.sweep_init) idx_r <= '0;
      // Probe step evaluation.
      if (cmd.eval) begin
        if (r_tomb && !have_tomb_r) begin
          have_tomb_r <= 1'b1;
          tomb_r <= idx_r;
        end
        if (r_hit) begin
          hit_r <= 1'b1;
          pos_r <= idx_r;
          old_size_r <= rd_size;
          old_flags_r <= rd_flags;
        end else if (r_empty) begin
          reuse_r <= 1'b1;
          pos_r <= have_tomb_r ? tomb_r : idx_r;
          old_flags_r <= have_tomb_r ? 3'b010 : 3'b000;
        end else if (have_tomb_r || r_tomb) begin
          reuse_r <= 1'b1;
          pos_r <= have_tomb_r ? tomb_r : idx_r;
          old_flags_r <= 3'b010;
        end
      end
      // Commit of single-entry requests.
      if (cmd.commit) begin
        case (req_r)
          gcht_pkg::REQ_INSERT: begin
            if (hit_r) begin
              alloc_r <= sat_add(sat_sub(alloc_r, 64'(old_size_r)), 64'(size_r));
            end else if (ins_new_ok) begin
              if (!old_flags_r[gcht_pkg::FL_TOMB]) count_r <= count_r + CW'(1);
              alloc_r <= sat_add(alloc_r, 64'(size_r));
            end else begin
              st_r <= gcht_pkg::ST_FULL;
            end
            if (hit_r || ins_new_ok) begin
              if (addr_r < low_r) low_r <= addr_r;
              if (top > high_r) high_r <= top;
            end
          end
          gcht_pkg::REQ_REMOVE: begin
            if (hit_r) begin
              freed_r <= 64'(old_size_r);
              alloc_r <= sat_sub(alloc_r, 64'(old_size_r));
            end else st_r <= gcht_pkg::ST_NFND;
          end
          default: if (!hit_r) st_r <= gcht_pkg::ST_NFND;
        endcase
      end
      // Sweep step.
      if (cmd.sweep_eval && r_use && !rd_flags[gcht_pkg::FL_MARK]) begin
        freed_r <= sat_add(freed_r, 64'(rd_size));
        alloc_r <= sat_sub(alloc_r, 64'(rd_size));
      end
      if (cmd.thr_mul) begin
        thr_hi_r <= alloc_r[63:32] * grow_r;
        thr_lo_r <= alloc_r[31:0] * grow_r;
      end
      if (cmd.thr_set) begin
        thr_r <= (thr_hi_r[36:32] != '0) ? '1
                 : sat_add({thr_hi_r[31:0], 32'd0}, 64'(thr_lo_r));
      end
      if (cmd.result) begin
        out_valid <= 1'b1;
        o_status <= (req_r > gcht_pkg::REQ_SWEEP) ? gcht_pkg::ST_NFND
                  : sts.addr_zero ? gcht_pkg::ST_BADDR
                  : sts.mark_oob ? gcht_pkg::ST_NFND : st_r;
        o_found <= hit_r && !sts.addr_zero && !sts.mark_oob
                   && req_r < gcht_pkg::REQ_SWEEP;
        o_esize <= (hit_r && !sts.addr_zero && !sts.mark_oob
                    && req_r < gcht_pkg::REQ_SWEEP) ? old_size_r : 32'd0;
        o_total <= alloc_r;
        o_freed <= freed_r;
        o_due <= alloc_r > thr_r;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/gc_allocation_hash_table.sv
// Top level of the allocation hash table for a mark-sweep collector.
// Joins gcht_ctrl and gcht_dp; depends on gcht_pkg.
//
// Requests enter on the in_ stream (insert, lookup, remove, mark, sweep)
// and each gives exactly one result on the out_ stream. One request is
// worked at a time. Insert, lookup, remove and mark first hash the address
// and load the probe index, then take a read and an evaluate step per probe
// through the single-port entry memory, then one commit and the result.
// Sweep walks every entry with a read and a sweep step each. Bad requests
// go straight to the result. The next request can be taken in the cycle
// after the result is loaded. After reset the block runs a clearing pass
// over the entry memory and takes no request in that time.
// Configuration writes belong between requests. The result sits in an output
// register; when the receiver stalls the block holds that result and waits
// for it to be taken before delivering the next.
module gc_allocation_hash_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // address[63:0], alloc_size[95:64]
  input  logic [2:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // status[1:0], found[2], entry_size[34:3],
                                   // bytes_total[98:35], freed_bytes[162:99],
                                   // collect_due[163], zero fill
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [31:0]  cfg_data
);

  gcht_pkg::gcht_cmd_t cmd;
  gcht_pkg::gcht_sts_t sts;
  logic in_fire;
  logic [1:0] st;
  logic fnd, due;
  logic [31:0] esz;
  logic [63:0] tot, frd;

  assign in_fire = in_tvalid && in_tready;

  gcht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_tvalid && !out_tready), .sts(sts),
    .in_ready(in_tready), .cmd(cmd)
  );

  gcht_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req(in_tuser), .in_addr(in_tdata[63:0]), .in_size(in_tdata[95:64]),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .out_take(out_tready), .out_valid(out_tvalid),
    .o_status(st), .o_found(fnd), .o_esize(esz), .o_total(tot),
    .o_freed(frd), .o_due(due)
  );

  assign out_tdata = {4'd0, due, frd, tot, esz, fnd, st};

  // A stalled result stays valid and unchanged.
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
  // Found implies an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> (out_tdata[1:0] == gcht_pkg::ST_OK))
    else $error("found with error status");
  // Not ready in the cycle after an accept.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("ready right after accept");

endmodule
